// ===== hdl/periodic_task_dispatch_table_defines.svh =====
// Assertion macros for the task dispatch table.
`ifndef PERIODIC_TASK_DISPATCH_TABLE_DEFINES_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

`define PTDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PTDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PTDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PTDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ptdt_pkg.sv =====
`timescale 1ns / 1ps

package ptdt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_RETIME = 2'd2,
    REQ_TICK   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  task_slot;
    logic [15:0] delay_value;
    logic [15:0] period_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] fired_slot;
    logic       fired;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

// ===== hdl/periodic_task_dispatch_table.sv =====
`timescale 1ns / 1ps
// Periodic task dispatch table.
// Input channel in_valid / in_stall / in_data carries one request transaction:
// add, delete, retime or tick. Result channel out_valid / out_stall / out_data
// returns the results; out_data.last marks the final result of a request.
// Add, delete and retime each give one result: S_DONE loads it into the output
// register when the output is free, and the block then returns to idle.
// A tick walks the allocated slots in index order through one shared
// decrement-and-compare unit, one slot per cycle from the countdown and
// period memories unless a stalled output pauses the walk; each due slot
// gives one result, and a tick with no due slot gives a single result with
// fired low. S_DONE then loads the final result into the output register.
// in_stall stays high from acceptance until the final result is loaded into
// the output register; the next request is taken while that result waits.
// A stalled output holds its result and the slot walk pauses on the slot
// that needs to emit.
// Reset empties the table: all live bits clear and the allocation count
// returns to zero. Memory contents are not cleared; a slot is read only after
// an add has written it.
module periodic_task_dispatch_table
  import ptdt_pkg::*;
#(
  parameter int MAX_TASKS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  `include "periodic_task_dispatch_table_defines.svh"

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int USED_W = $clog2(MAX_TASKS + 1);
  localparam int SAT_W  = (COUNT_WIDTH > 17) ? COUNT_WIDTH : 17;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DONE
  } state_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [16:0] v);
    logic [SAT_W-1:0] ext;
    logic [SAT_W-1:0] lim;
    ext = SAT_W'(v);
    lim = SAT_W'({COUNT_WIDTH{1'b1}});
    if (ext > lim) begin
      sat_count = {COUNT_WIDTH{1'b1}};
    end else begin
      sat_count = COUNT_WIDTH'(ext);
    end
  endfunction

  state_t                  state_r;
  logic [USED_W-1:0]       used_r;
  logic [MAX_TASKS-1:0]    live_r;
  logic [IDX_W-1:0]        idx_r;
  out_item_t               done_res_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [COUNT_WIDTH-1:0]  cnt_mem [MAX_TASKS];
  logic [COUNT_WIDTH-1:0]  per_mem [MAX_TASKS];
  logic [COUNT_WIDTH-1:0]  cnt_rd_r;
  logic [COUNT_WIDTH-1:0]  per_rd_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    out_load;
  out_item_t               acc_res;
  logic                    full;
  logic                    slot_ok;
  logic [IDX_W-1:0]        req_idx;
  logic                    active;
  logic                    fire;
  logic                    adv;
  logic                    at_last;
  logic [IDX_W-1:0]        rd_addr;
  logic                    cnt_we;
  logic                    per_we;
  logic [IDX_W-1:0]        wr_addr;
  logic [COUNT_WIDTH-1:0]  cnt_wdata;
  logic [COUNT_WIDTH-1:0]  per_wdata;
  logic [COUNT_WIDTH-1:0]  cnt_dec;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full    = (used_r == USED_W'(MAX_TASKS));
  assign req_idx = IDX_W'(in_data.task_slot);
  assign slot_ok = (7'(in_data.task_slot) < 7'(MAX_TASKS)) && live_r[req_idx];

  assign cnt_dec = cnt_rd_r - COUNT_WIDTH'(1);
  assign active  = live_r[idx_r] && (cnt_rd_r != '0);
  assign fire    = active && (cnt_rd_r == COUNT_WIDTH'(1));
  assign adv     = (state_r == S_EVAL) && !(fire && done_res_r.fired && !out_free);
  assign at_last = ((USED_W'(idx_r) + USED_W'(1)) == used_r);

  assign out_load = (adv && fire && done_res_r.fired) ||
                    ((state_r == S_DONE) && out_free);

  always_comb begin
    acc_res = '{fired_slot: 3'd0, fired: 1'b0, status: ST_OK, last: 1'b1};
    unique case (req_type_t'(in_data.req_type))
      REQ_ADD: begin
        if (full) begin
          acc_res.status = ST_FULL;
        end else begin
          acc_res.fired_slot = 3'(used_r);
        end
      end
      REQ_DELETE, REQ_RETIME: begin
        if (!slot_ok) begin
          acc_res.status = ST_NO_SLOT;
        end
      end
      REQ_TICK: begin
        acc_res.last = 1'b1;
      end
      default: begin
        acc_res.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    priority if (state_r == S_IDLE) begin
      rd_addr = '0;
    end else if (adv) begin
      rd_addr = idx_r + IDX_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    per_we    = 1'b0;
    wr_addr   = idx_r;
    cnt_wdata = fire ? per_rd_r : cnt_dec;
    per_wdata = sat_count({1'b0, in_data.period_value});
    if (in_acc) begin
      unique case (req_type_t'(in_data.req_type))
        REQ_ADD: begin
          wr_addr   = used_r[IDX_W-1:0];
          cnt_wdata = sat_count(17'(in_data.delay_value) + 17'd1);
          cnt_we    = !full;
          per_we    = !full;
        end
        REQ_RETIME: begin
          wr_addr   = req_idx;
          cnt_wdata = sat_count({1'b0, in_data.delay_value});
          cnt_we    = slot_ok;
          per_we    = slot_ok;
        end
        REQ_DELETE, REQ_TICK: begin
          cnt_we = 1'b0;
        end
        default: begin
          cnt_we = 1'b0;
        end
      endcase
    end else if (adv && active) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
    per_rd_r <= per_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r      <= '0;
            done_res_r <= acc_res;
            unique case (req_type_t'(in_data.req_type))
              REQ_ADD: begin
                if (!full) begin
                  live_r[used_r[IDX_W-1:0]] <= 1'b1;
                  used_r <= used_r + USED_W'(1);
                end
                state_r <= S_DONE;
              end
              REQ_DELETE: begin
                if (slot_ok) begin
                  live_r[req_idx] <= 1'b0;
                end
                state_r <= S_DONE;
              end
              REQ_RETIME: begin
                state_r <= S_DONE;
              end
              REQ_TICK: begin
                state_r <= (used_r == '0) ? S_DONE : S_EVAL;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_EVAL: begin
          if (adv) begin
            if (fire) begin
              if (done_res_r.fired) begin
                out_data_r <= '{fired_slot: done_res_r.fired_slot, fired: 1'b1,
                                status: ST_OK, last: 1'b0};
              end
              done_res_r <= '{fired_slot: 3'(idx_r), fired: 1'b1, status: ST_OK,
                              last: 1'b1};
            end
            idx_r <= idx_r + IDX_W'(1);
            if (at_last) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= done_res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `PTDT_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= USED_W'(MAX_TASKS))
  `PTDT_ASSERT_IMP(a_nonlast_in_tick, clk, rst_n, out_valid_r && !out_data_r.last,
                   done_res_r.fired && (state_r != S_IDLE))
  `PTDT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall)

endmodule

// ===== dv/tb_periodic_task_dispatch_table.sv =====
`timescale 1ns / 1ps

module tb_periodic_task_dispatch_table;
  import ptdt_pkg::*;

  localparam int NUM_SLOTS = 8;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  periodic_task_dispatch_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  logic [15:0]          slot_count  [NUM_SLOTS];
  logic [15:0]          slot_period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_alive;
  int                   alloc_count;

  out_item_t expected_results [$];
  int        err_count;
  int        burst_left;
  int        stall_mode;
  int        stall_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_periodic_task_dispatch_table: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic in_item_t make_req(input req_type_t kind, input int slot,
                                        input int delay, input int period);
    in_item_t req;
    req.req_type     = kind;
    req.task_slot    = slot[2:0];
    req.delay_value  = delay[15:0];
    req.period_value = period[15:0];
    return req;
  endfunction

  task automatic predict_dispatch(input in_item_t req);
    out_item_t   res;
    logic [16:0] sum;
    int          n;
    res      = '0;
    res.last = 1'b1;
    n        = 0;
    case (req.req_type)
      REQ_ADD: begin
        if (alloc_count >= NUM_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          sum = {1'b0, req.delay_value} + 17'd1;
          slot_count[alloc_count]  = sum[16] ? 16'hFFFF : sum[15:0];
          slot_period[alloc_count] = req.period_value;
          slot_alive[alloc_count]  = 1'b1;
          res.fired_slot           = alloc_count[2:0];
          alloc_count++;
        end
        expected_results.push_back(res);
      end
      REQ_DELETE, REQ_RETIME: begin
        if (!slot_alive[req.task_slot]) begin
          res.status = ST_NO_SLOT;
        end else if (req.req_type == REQ_DELETE) begin
          slot_alive[req.task_slot]  = 1'b0;
          slot_count[req.task_slot]  = '0;
          slot_period[req.task_slot] = '0;
        end else begin
          slot_count[req.task_slot]  = req.delay_value;
          slot_period[req.task_slot] = req.period_value;
        end
        expected_results.push_back(res);
      end
      default: begin
        for (int i = 0; i < alloc_count; i++) begin
          if (slot_alive[i] && slot_count[i] != 0) begin
            slot_count[i] = slot_count[i] - 16'd1;
            if (slot_count[i] == 0) begin
              slot_count[i]  = slot_period[i];
              res.fired_slot = i[2:0];
              res.fired      = 1'b1;
              res.last       = 1'b0;
              expected_results.push_back(res);
              n++;
            end
          end
        end
        if (n == 0) begin
          expected_results.push_back(res);
        end else begin
          expected_results[expected_results.size()-1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic send_request(input in_item_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predict_dispatch(req);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.fired_slot !== want.fired_slot)
          report_mismatch($sformatf("fired_slot got %0d expected %0d",
                                    out_data.fired_slot, want.fired_slot));
        if (out_data.fired !== want.fired)
          report_mismatch($sformatf("fired got %0d expected %0d",
                                    out_data.fired, want.fired));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    out_data.status, want.status));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last got %0d expected %0d",
                                    out_data.last, want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ((stall_left % 5) < 2);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  task automatic test_empty_table();
    send_request(make_req(REQ_TICK, 0, 0, 0));
    send_request(make_req(REQ_DELETE, 0, 0, 0));
    send_request(make_req(REQ_RETIME, 7, 3, 3));
  endtask

  task automatic test_add_and_fire();
    send_request(make_req(REQ_ADD, 5, 0, 0));
    send_request(make_req(REQ_ADD, 2, 65534, 65535));
    send_request(make_req(REQ_ADD, 0, 1, 2));
    send_request(make_req(REQ_TICK, 0, 0, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0));
  endtask

  task automatic test_dormant_retime();
    send_request(make_req(REQ_RETIME, 0, 0, 5));
    send_request(make_req(REQ_TICK, 0, 0, 0));
    send_request(make_req(REQ_RETIME, 0, 1, 1));
    send_request(make_req(REQ_RETIME, 1, 1, 0));
    send_request(make_req(REQ_TICK, 0, 0, 0));
  endtask

  task automatic test_fill_table();
    send_request(make_req(REQ_ADD, 0, 0, 16'hAAAA));
    send_request(make_req(REQ_ADD, 0, 0, 16'h5555));
    send_request(make_req(REQ_ADD, 0, 0, 1));
    send_request(make_req(REQ_ADD, 0, 0, 0));
    send_request(make_req(REQ_ADD, 0, 0, 65535));
    send_request(make_req(REQ_ADD, 7, 9, 9));
  endtask

  task automatic test_all_due();
    send_request(make_req(REQ_RETIME, 1, 1, 1));
    send_request(make_req(REQ_RETIME, 2, 1, 3));
    send_request(make_req(REQ_TICK, 0, 0, 0));
  endtask

  task automatic test_delete();
    send_request(make_req(REQ_DELETE, 4, 0, 0));
    send_request(make_req(REQ_DELETE, 4, 0, 0));
    send_request(make_req(REQ_RETIME, 4, 1, 1));
    send_request(make_req(REQ_TICK, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    int pick;
    int slot;
    int delay;
    int period;
    for (int k = 0; k < 184; k++) begin
      pick   = $urandom_range(0, 99);
      slot   = $urandom_range(0, 7);
      pick   = $urandom_range(0, 99);
      delay  = $urandom_range(0, 9);
      delay  = (delay < 8) ? $urandom_range(0, 4) : (delay == 8) ? $urandom_range(0, 65534)
                                                                 : 65534;
      period = $urandom_range(0, 19);
      period = (period < 14) ? $urandom_range(0, 6) : (period < 17) ? 0
                                                                    : $urandom_range(0, 65535);
      if (pick < 46) begin
        send_request(make_req(REQ_TICK, slot, delay, period));
      end else if (pick < 84) begin
        send_request(make_req(REQ_RETIME, slot, delay, period));
      end else if (pick < 95) begin
        send_request(make_req(REQ_ADD, slot, $urandom_range(0, 65534),
                              $urandom_range(0, 65535)));
      end else begin
        if ($countones(slot_alive) <= 5)
          while (slot_alive[slot]) slot = $urandom_range(0, 7);
        send_request(make_req(REQ_DELETE, slot, delay, period));
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    slot_alive  = '0;
    alloc_count = 0;
    err_count   = 0;
    burst_left  = $urandom_range(1, 8);
    stall_mode  = 0;
    stall_left  = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_count[i]  = '0;
      slot_period[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_add_and_fire();
    test_dormant_retime();
    test_fill_table();
    test_all_due();
    test_delete();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_periodic_task_dispatch_table: clean");
    end else begin
      $display("tb_periodic_task_dispatch_table: errors");
    end
    $finish;
  end

endmodule

// ===== periodic_task_dispatch_table.f =====
+incdir+hdl
hdl/ptdt_pkg.sv
hdl/periodic_task_dispatch_table.sv
dv/tb_periodic_task_dispatch_table.sv
